@@ rtl/core/c5b_pkg.sv @@
// Shared types and constants for the 5x5 convolution block.
package c5b_pkg;

    // Arithmetic and kernel geometry
    localparam int DATA_W      = 32;
    localparam int FEAT_W      = 25;
    localparam int IDX_W       = 5;
    localparam int KSIZE       = 5;
    localparam int KTAPS       = KSIZE * KSIZE;
    localparam int NLINES      = KSIZE - 1;
    localparam int ROW_DATA_W  = NLINES * DATA_W;

    // Frame geometry
    localparam int MAX_WIDTH_DEF = 64;
    localparam int MAX_HEIGHT    = 64;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int IN_DIM_W      = 7;
    localparam int OUT_DIM_W     = 6;
    localparam int MIN_IN_DIM    = KSIZE;
    localparam int MIN_OUT_DIM   = 1;

    // Rectifier
    localparam logic [DATA_W-1:0] RECT_LIMIT = 32'h8000_0000;
    localparam int                RECT_SHIFT = 8;

    // Adder tree: products plus bias, padded to a power of two
    localparam int TREE_LEAVES = 32;
    localparam int TREE_LEVELS = $clog2(TREE_LEAVES);
    localparam int TREE_NODES  = TREE_LEAVES - 1;

    // Output queue
    localparam int FIFO_DEPTH = 16;

    // Configuration port
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 3'd0,
        REG_IN_HEIGHT  = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_BIAS       = 3'd4
    } cfg_reg_t;

    localparam logic [IN_DIM_W-1:0]  IN_WIDTH_RST   = 7'd33;
    localparam logic [IN_DIM_W-1:0]  IN_HEIGHT_RST  = 7'd33;
    localparam logic [OUT_DIM_W-1:0] OUT_WIDTH_RST  = 6'd28;
    localparam logic [OUT_DIM_W-1:0] OUT_HEIGHT_RST = 6'd28;
    localparam logic [DATA_W-1:0]    BIAS_RST       = 32'd66882;

    // Kind of an input beat
    typedef enum logic {
        OP_WEIGHT = 1'b0,
        OP_PIXEL  = 1'b1
    } op_t;

    // One queued result
    typedef struct packed {
        logic              last;
        logic [FEAT_W-1:0] feature;
    } result_t;

endpackage

@@ rtl/core/c5b_cell.sv @@
// One kernel tap: weight, window pixel and registered product.
module c5b_cell
    import c5b_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic [DATA_W-1:0] pixel_in,
    input  logic              load_en,
    input  logic [DATA_W-1:0] weight_in,
    output logic [DATA_W-1:0] pixel_out,
    output logic [DATA_W-1:0] product_out
);

    logic [DATA_W-1:0] weight_reg;
    logic [DATA_W-1:0] pixel_reg;
    logic [DATA_W-1:0] product_reg;

    // Tap state: pixel moves one place along the row per pixel beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
            pixel_reg  <= '0;
        end else begin
            if (load_en) begin
                weight_reg <= weight_in;
            end
            if (shift_en) begin
                pixel_reg <= pixel_in;
            end
        end
    end

    // Low 32 bits of the product, wrapping
    always_ff @(posedge aclk) begin
        product_reg <= weight_reg * pixel_reg;
    end

    assign pixel_out   = pixel_reg;
    assign product_out = product_reg;

endmodule

@@ rtl/core/c5b_line_buf.sv @@
// Four line buffers held as one memory row per column.
module c5b_line_buf
    import c5b_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic [ROW_DATA_W-1:0]        rd_row,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [ROW_DATA_W-1:0]        wr_row
);

    // Lowest word is the newest line, highest the oldest
    logic [ROW_DATA_W-1:0] mem [MAX_WIDTH];
    logic [ROW_DATA_W-1:0] rd_row_reg;

    always_ff @(posedge aclk) begin
        rd_row_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
    end

    assign rd_row = rd_row_reg;

endmodule

@@ rtl/core/c5b_sum_tree.sv @@
// Registered binary adder tree over the tap products and the bias.
module c5b_sum_tree
    import c5b_pkg::*;
(
    input  logic              aclk,
    input  logic [DATA_W-1:0] products [KTAPS],
    input  logic [DATA_W-1:0] bias,
    output logic [DATA_W-1:0] sum
);

    logic [DATA_W-1:0] leaf [TREE_LEAVES];
    // Heap order: node i adds children 2i+1 and 2i+2
    logic [DATA_W-1:0] node_reg [TREE_NODES];

    // Leaves: products, then bias, then zero padding
    always_comb begin
        for (int k = 0; k < TREE_LEAVES; k++) begin
            if (k < KTAPS) begin
                leaf[k] = products[k];
            end else if (k == KTAPS) begin
                leaf[k] = bias;
            end else begin
                leaf[k] = '0;
            end
        end
    end

    for (genvar i = 0; i < TREE_NODES; i++) begin : g_node
        if (2 * i + 1 >= TREE_NODES) begin : g_leaf_add
            always_ff @(posedge aclk) begin
                node_reg[i] <= leaf[2 * i + 1 - TREE_NODES] + leaf[2 * i + 2 - TREE_NODES];
            end
        end else begin : g_node_add
            always_ff @(posedge aclk) begin
                node_reg[i] <= node_reg[2 * i + 1] + node_reg[2 * i + 2];
            end
        end
    end

    assign sum = node_reg[0];

endmodule

@@ rtl/core/c5b_out_fifo.sv @@
// Small result queue between the datapath and the master port.
module c5b_out_fifo
    import c5b_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  result_t wr_data,
    input  logic    rd_en,
    output result_t rd_data,
    output logic    not_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t             store [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = store[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule

@@ rtl/core/conv5x5_bias_relu_shift.sv @@
// Top level of the streaming 5x5 convolution with bias and rectifier.
//
// Takes one beat per clock, weight loads and pixels alike, with no gaps of its own.
// A pixel that completes an output position yields its result after its beat passes the
// line store read, window shift, product, five adder-tree levels and the queue write.
// Results wait in a 16-entry queue; s_tready falls only when 16 results are
// outstanding, so a stalled master side stops the slave side after that many.
// Weight beats give no result. The line store is not cleared after reset.
module conv5x5_bias_relu_shift
    import c5b_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // weight_index[4:0], data[36:5], zero pad
    input  logic                 s_tuser,   // operation
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // feature[24:0], zero pad
    output logic                 m_tlast,   // last_of_frame
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = ($clog2(MAX_WIDTH + 1) > IN_DIM_W) ?
                                $clog2(MAX_WIDTH + 1) : IN_DIM_W;
    localparam int PIPE_DELAY = 2 + TREE_LEVELS;
    localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

    // ---------------- configuration registers ----------------
    logic [IN_DIM_W-1:0]  in_width_reg, in_height_reg;
    logic [OUT_DIM_W-1:0] out_width_reg, out_height_reg;
    logic [DATA_W-1:0]    bias_reg;
    logic                 cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg   <= IN_WIDTH_RST;
            in_height_reg  <= IN_HEIGHT_RST;
            out_width_reg  <= OUT_WIDTH_RST;
            out_height_reg <= OUT_HEIGHT_RST;
            bias_reg       <= BIAS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_IN_WIDTH:   in_width_reg   <= cfg_data[IN_DIM_W-1:0];
                REG_IN_HEIGHT:  in_height_reg  <= cfg_data[IN_DIM_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data[OUT_DIM_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg_data[OUT_DIM_W-1:0];
                REG_BIAS:       bias_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- clamped frame geometry ----------------
    logic [DIM_W-1:0]    iw, ow, iw_ext, ow_ext, ow_hi;
    logic [IN_DIM_W-1:0] ih, oh, oh_ext, oh_hi;

    always_comb begin
        iw_ext = DIM_W'(in_width_reg);
        priority if (iw_ext < DIM_W'(MIN_IN_DIM)) begin
            iw = DIM_W'(MIN_IN_DIM);
        end else if (iw_ext > DIM_W'(MAX_WIDTH)) begin
            iw = DIM_W'(MAX_WIDTH);
        end else begin
            iw = iw_ext;
        end

        priority if (in_height_reg < IN_DIM_W'(MIN_IN_DIM)) begin
            ih = IN_DIM_W'(MIN_IN_DIM);
        end else if (in_height_reg > IN_DIM_W'(MAX_HEIGHT)) begin
            ih = IN_DIM_W'(MAX_HEIGHT);
        end else begin
            ih = in_height_reg;
        end

        ow_ext = DIM_W'(out_width_reg);
        ow_hi  = iw - DIM_W'(NLINES);
        priority if (ow_ext < DIM_W'(MIN_OUT_DIM)) begin
            ow = DIM_W'(MIN_OUT_DIM);
        end else if (ow_ext > ow_hi) begin
            ow = ow_hi;
        end else begin
            ow = ow_ext;
        end

        oh_ext = IN_DIM_W'(out_height_reg);
        oh_hi  = ih - IN_DIM_W'(NLINES);
        priority if (oh_ext < IN_DIM_W'(MIN_OUT_DIM)) begin
            oh = IN_DIM_W'(MIN_OUT_DIM);
        end else if (oh_ext > oh_hi) begin
            oh = oh_hi;
        end else begin
            oh = oh_ext;
        end
    end

    // ---------------- input beat decode and position counters ----------------
    logic [CRED_W-1:0]   credit_reg, credit_next;
    logic                s_accept, pix_accept, pix_emit, pix_last;
    logic [IDX_W-1:0]    in_index;
    logic [DATA_W-1:0]   in_data;
    logic [COL_W-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]    row_cnt_reg, row_cnt_next;
    logic [DIM_W-1:0]    col_ext, col_off;
    logic [IN_DIM_W-1:0] row_ext, row_off;

    assign in_index   = s_tdata[IDX_W-1:0];
    assign in_data    = s_tdata[IDX_W+DATA_W-1:IDX_W];
    assign s_tready   = (credit_reg < CRED_W'(FIFO_DEPTH));
    assign s_accept   = s_tvalid && s_tready;
    assign pix_accept = s_accept && (op_t'(s_tuser) == OP_PIXEL);

    always_comb begin
        col_ext  = DIM_W'(col_cnt_reg);
        row_ext  = IN_DIM_W'(row_cnt_reg);
        col_off  = col_ext - DIM_W'(NLINES);
        row_off  = row_ext - IN_DIM_W'(NLINES);
        pix_emit = (col_ext >= DIM_W'(NLINES)) && (row_ext >= IN_DIM_W'(NLINES))
                   && (col_off < ow) && (row_off < oh);
        pix_last = (col_off == ow - 1'b1) && (row_off == oh - 1'b1);

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (pix_accept) begin
            if (col_ext + 1'b1 >= iw) begin
                col_cnt_next = '0;
                if (row_ext + 1'b1 >= ih) begin
                    row_cnt_next = '0;
                end else begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end else begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- stage 1: beat registered, line store read ----------------
    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic [IDX_W-1:0]    s1_index_reg;
    logic [DATA_W-1:0]   s1_data_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_emit_reg, s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            s1_emit_reg  <= pix_accept && pix_emit;
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg    <= op_t'(s_tuser);
        s1_index_reg <= in_index;
        s1_data_reg  <= in_data;
        s1_col_reg   <= col_cnt_reg;
        s1_last_reg  <= pix_last;
    end

    logic [ROW_DATA_W-1:0] rd_row;
    logic                  s1_pixel, s1_load;

    assign s1_pixel = s1_valid_reg && (s1_op_reg == OP_PIXEL);
    assign s1_load  = s1_valid_reg && (s1_op_reg == OP_WEIGHT);

    // Each column shifts its lines up by one and takes the new pixel as the newest
    c5b_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_addr (col_cnt_reg),
        .rd_row  (rd_row),
        .wr_en   (s1_pixel),
        .wr_addr (s1_col_reg),
        .wr_row  ({rd_row[ROW_DATA_W-DATA_W-1:0], s1_data_reg})
    );

    // ---------------- window: chain of tap cells ----------------
    logic [DATA_W-1:0] col_vec   [KSIZE];
    logic [DATA_W-1:0] cell_pix  [KTAPS];
    logic [DATA_W-1:0] cell_prod [KTAPS];

    // Oldest line feeds window row 0, the new pixel row KSIZE-1
    always_comb begin
        for (int l = 0; l < NLINES; l++) begin
            col_vec[l] = rd_row[(NLINES-l)*DATA_W-1 -: DATA_W];
        end
        col_vec[KSIZE-1] = s1_data_reg;
    end

    for (genvar k = 0; k < KTAPS; k++) begin : g_cell
        logic [DATA_W-1:0] tap_in;
        if ((k % KSIZE) == KSIZE - 1) begin : g_edge
            assign tap_in = col_vec[k / KSIZE];
        end else begin : g_inner
            assign tap_in = cell_pix[k + 1];
        end

        c5b_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (s1_pixel),
            .pixel_in    (tap_in),
            .load_en     (s1_load && (s1_index_reg == IDX_W'(k))),
            .weight_in   (s1_data_reg),
            .pixel_out   (cell_pix[k]),
            .product_out (cell_prod[k])
        );
    end

    // ---------------- sum, rectify, queue ----------------
    logic [DATA_W-1:0] sum;

    c5b_sum_tree u_sum_tree (
        .aclk     (aclk),
        .products (cell_prod),
        .bias     (bias_reg),
        .sum      (sum)
    );

    // Emit flags follow their pixel down the datapath
    logic [PIPE_DELAY-1:0] emit_pipe_reg;
    logic [PIPE_DELAY-1:0] last_pipe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_pipe_reg <= '0;
        end else begin
            emit_pipe_reg <= {emit_pipe_reg[PIPE_DELAY-2:0], s1_emit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        last_pipe_reg <= {last_pipe_reg[PIPE_DELAY-2:0], s1_last_reg};
    end

    result_t res_in, res_out;
    logic    fifo_wr, out_accept;

    always_comb begin
        res_in.last = last_pipe_reg[PIPE_DELAY-1];
        if (sum > RECT_LIMIT) begin
            res_in.feature = '0;
        end else begin
            res_in.feature = FEAT_W'(sum >> RECT_SHIFT);
        end
    end

    assign fifo_wr    = emit_pipe_reg[PIPE_DELAY-1];
    assign out_accept = m_tvalid && m_tready;

    c5b_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (fifo_wr),
        .wr_data   (res_in),
        .rd_en     (out_accept),
        .rd_data   (res_out),
        .not_empty (m_tvalid)
    );

    assign m_tdata = {{(32-FEAT_W){1'b0}}, res_out.feature};
    assign m_tlast = res_out.last;

    // Queue slots reserved by accepted emitting pixels, freed by master beats
    always_comb begin
        credit_next = credit_reg;
        if ((pix_accept && pix_emit) && !out_accept) begin
            credit_next = credit_reg + 1'b1;
        end else if (out_accept && !(pix_accept && pix_emit)) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= CRED_W'(FIFO_DEPTH))
        else $error("reserved result slots exceed queue depth");

    a_out_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (credit_reg != '0))
        else $error("queued result without a reserved slot");

    // Stage 1 register plus the flag pipe
    a_emit_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_accept && pix_emit) |-> ##(PIPE_DELAY + 1) fifo_wr)
        else $error("emitting pixel did not reach the result queue");

endmodule
